>>> design/heap_sort_engine_assert.svh
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// condition holds in the same cycle
`define HSE_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// condition holds in the next cycle
`define HSE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/hse_pkg.sv
package hse_pkg;

    localparam int KEY_BITS   = 32;
    localparam int CAPACITY   = 64;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int CHILD_BITS = IDX_BITS + 2;
    localparam int TOT_BITS   = 12;
    localparam logic [TOT_BITS-1:0] TOT_MAX = '1;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [IDX_BITS-1:0] idx_t;

    // one access to the key store per cycle: a write and a read
    typedef struct packed {
        logic we;
        idx_t waddr;
        key_t wdata;
        idx_t raddr;
    } ram_req_t;

endpackage

>>> design/hse_ram.sv
module hse_ram (
    input  logic              aclk,
    input  hse_pkg::ram_req_t req,
    output hse_pkg::key_t     rdata
);

    hse_pkg::key_t mem [hse_pkg::CAPACITY];
    hse_pkg::key_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/heap_sort_engine.sv
// loading: one key per cycle, no result until the key marked last
// sort: paced by the single read port of the key store (one read issued per cycle,
// data returned in the next cycle)
// results: each key read from the key store, the next only after m_tready takes it
// reset: synchronous, active low; clears counts, flags and control, not the key store
module heap_sort_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // key_in[31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // key_out[31:0], compare_total[43:32],
                                  // assign_total[55:44], overflowed[56], zeros
    output logic        m_tlast
);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_PLAN  = 4'd1;
    localparam logic [3:0] ST_FETCH = 4'd2;
    localparam logic [3:0] ST_GETV  = 4'd3;
    localparam logic [3:0] ST_SWAP0 = 4'd4;
    localparam logic [3:0] ST_SWAP1 = 4'd5;
    localparam logic [3:0] ST_SWAP2 = 4'd6;
    localparam logic [3:0] ST_RDL   = 4'd7;
    localparam logic [3:0] ST_RDR   = 4'd8;
    localparam logic [3:0] ST_CMP   = 4'd9;
    localparam logic [3:0] ST_ERD   = 4'd10;
    localparam logic [3:0] ST_ELD   = 4'd11;
    localparam logic [3:0] ST_EOUT  = 4'd12;

    localparam logic [hse_pkg::CNT_BITS-1:0] CAP_CNT = hse_pkg::CNT_BITS'(hse_pkg::CAPACITY);

    function automatic logic [hse_pkg::TOT_BITS-1:0] sat_add(
        input logic [hse_pkg::TOT_BITS-1:0] cur,
        input logic [1:0]                   by
    );
        logic [hse_pkg::TOT_BITS:0] s;
        s = {1'b0, cur} + {{(hse_pkg::TOT_BITS-1){1'b0}}, by};
        if (s > {1'b0, hse_pkg::TOT_MAX}) begin
            return hse_pkg::TOT_MAX;
        end
        return s[hse_pkg::TOT_BITS-1:0];
    endfunction

    logic [3:0] state_reg, state_next;
    logic [hse_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic drop_reg, drop_next;
    logic [hse_pkg::TOT_BITS-1:0] cmp_reg, cmp_next;
    logic [hse_pkg::TOT_BITS-1:0] asg_reg, asg_next;
    logic [hse_pkg::CNT_BITS-1:0] i_reg, i_next;
    logic build_reg, build_next;
    logic [hse_pkg::CNT_BITS-1:0] size_reg, size_next;
    hse_pkg::idx_t root_reg, root_next;
    hse_pkg::key_t v_reg, v_next;
    hse_pkg::key_t lval_reg, lval_next;
    logic [hse_pkg::CNT_BITS-1:0] k_reg, k_next;
    hse_pkg::key_t out_key_reg, out_key_next;
    logic out_last_reg, out_last_next;
    logic out_valid_reg, out_valid_next;

    hse_pkg::ram_req_t ram_req;
    hse_pkg::key_t     ram_rdata;

    logic [hse_pkg::CHILD_BITS-1:0] child_l, child_r, size_ext;
    logic l_ok, r_ok, gl, gr, in_take, has_room;
    hse_pkg::key_t top_val;
    logic [hse_pkg::CNT_BITS-1:0] load_n;

    hse_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign child_l  = {1'b0, root_reg, 1'b1};
    assign child_r  = child_l + hse_pkg::CHILD_BITS'(1);
    assign size_ext = {1'b0, size_reg};
    assign l_ok     = child_l < size_ext;
    assign r_ok     = child_r < size_ext;
    assign gl       = $signed(lval_reg) > $signed(v_reg);
    assign top_val  = gl ? lval_reg : v_reg;
    assign gr       = r_ok && ($signed(ram_rdata) > $signed(top_val));

    assign s_tready = (state_reg == ST_LOAD);
    assign in_take  = s_tvalid && s_tready;
    assign has_room = cnt_reg < CAP_CNT;
    assign load_n   = has_room ? cnt_reg + hse_pkg::CNT_BITS'(1) : cnt_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        cmp_next       = cmp_reg;
        asg_next       = asg_reg;
        i_next         = i_reg;
        build_next     = build_reg;
        size_next      = size_reg;
        root_next      = root_reg;
        v_next         = v_reg;
        lval_next      = lval_reg;
        k_next         = k_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = root_reg;
        ram_req.wdata  = v_reg;
        ram_req.raddr  = root_reg;

        case (state_reg)
            ST_LOAD: begin
                if (in_take) begin
                    if (has_room) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = cnt_reg[hse_pkg::IDX_BITS-1:0];
                        ram_req.wdata = s_tdata[hse_pkg::KEY_BITS-1:0];
                    end else begin
                        drop_next = 1'b1;
                    end
                    cnt_next = load_n;
                    if (s_tlast) begin
                        i_next     = load_n >> 1;
                        build_next = 1'b1;
                        state_next = ST_PLAN;
                    end
                end
            end
            ST_PLAN: begin
                if (build_reg) begin
                    if (i_reg != '0) begin
                        root_next  = hse_pkg::IDX_BITS'(i_reg - hse_pkg::CNT_BITS'(1));
                        i_next     = i_reg - hse_pkg::CNT_BITS'(1);
                        size_next  = cnt_reg;
                        state_next = ST_FETCH;
                    end else begin
                        build_next = 1'b0;
                        i_next     = cnt_reg;
                    end
                end else if (i_reg > hse_pkg::CNT_BITS'(1)) begin
                    size_next  = i_reg - hse_pkg::CNT_BITS'(1);
                    i_next     = i_reg - hse_pkg::CNT_BITS'(1);
                    root_next  = '0;
                    state_next = ST_SWAP0;
                end else begin
                    k_next     = '0;
                    state_next = ST_ERD;
                end
            end
            ST_FETCH: begin
                ram_req.raddr = root_reg;
                state_next    = ST_GETV;
            end
            ST_GETV: begin
                v_next     = ram_rdata;
                state_next = ST_RDL;
            end
            ST_SWAP0: begin
                ram_req.raddr = '0;
                state_next    = ST_SWAP1;
            end
            ST_SWAP1: begin
                lval_next     = ram_rdata;
                ram_req.raddr = size_reg[hse_pkg::IDX_BITS-1:0];
                state_next    = ST_SWAP2;
            end
            ST_SWAP2: begin
                // largest key goes to the end, old end key sifts down from the root
                v_next        = ram_rdata;
                ram_req.we    = 1'b1;
                ram_req.waddr = size_reg[hse_pkg::IDX_BITS-1:0];
                ram_req.wdata = lval_reg;
                asg_next      = sat_add(asg_reg, 2'd3);
                state_next    = ST_RDL;
            end
            ST_RDL: begin
                if (l_ok) begin
                    ram_req.raddr = child_l[hse_pkg::IDX_BITS-1:0];
                    state_next    = ST_RDR;
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = root_reg;
                    ram_req.wdata = v_reg;
                    state_next    = ST_PLAN;
                end
            end
            ST_RDR: begin
                lval_next     = ram_rdata;
                ram_req.raddr = child_r[hse_pkg::IDX_BITS-1:0];
                state_next    = ST_CMP;
            end
            ST_CMP: begin
                cmp_next   = sat_add(cmp_reg, r_ok ? 2'd2 : 2'd1);
                ram_req.we = 1'b1;
                if (gr) begin
                    ram_req.wdata = ram_rdata;
                    root_next     = child_r[hse_pkg::IDX_BITS-1:0];
                    asg_next      = sat_add(asg_reg, 2'd3);
                    state_next    = ST_RDL;
                end else if (gl) begin
                    ram_req.wdata = lval_reg;
                    root_next     = child_l[hse_pkg::IDX_BITS-1:0];
                    asg_next      = sat_add(asg_reg, 2'd3);
                    state_next    = ST_RDL;
                end else begin
                    ram_req.wdata = v_reg;
                    state_next    = ST_PLAN;
                end
            end
            ST_ERD: begin
                ram_req.raddr = k_reg[hse_pkg::IDX_BITS-1:0];
                state_next    = ST_ELD;
            end
            ST_ELD: begin
                out_key_next   = ram_rdata;
                out_last_next  = (k_reg + hse_pkg::CNT_BITS'(1)) == cnt_reg;
                out_valid_next = 1'b1;
                state_next     = ST_EOUT;
            end
            ST_EOUT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        cmp_next   = '0;
                        asg_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + hse_pkg::CNT_BITS'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            cmp_reg       <= '0;
            asg_reg       <= '0;
            i_reg         <= '0;
            build_reg     <= 1'b0;
            size_reg      <= '0;
            root_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            cmp_reg       <= cmp_next;
            asg_reg       <= asg_next;
            i_reg         <= i_next;
            build_reg     <= build_next;
            size_reg      <= size_next;
            root_reg      <= root_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg       <= v_next;
        lval_reg    <= lval_next;
        out_key_reg <= out_key_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, drop_reg, asg_reg, cmp_reg, out_key_reg};

    `include "heap_sort_engine_assert.svh"

    `HSE_ASSERT_NOW(a_load_not_during_output, s_tready, !m_tvalid,
        "input open during output")
    `HSE_ASSERT_NOW(a_count_in_range, 1'b1, cnt_reg <= CAP_CNT,
        "key count beyond capacity")
    `HSE_ASSERT_NEXT(a_sift_moves_down,
        (state_reg == ST_CMP) && (state_next == ST_RDL),
        root_reg > $past(root_reg), "sift did not descend")
    `HSE_ASSERT_NOW(a_last_at_end, m_tvalid && m_tlast,
        (k_reg + hse_pkg::CNT_BITS'(1)) == cnt_reg, "last flag off the final key")

endmodule
